### rtl/cfb_pkg.sv
// Shared types, constants and the CRC-16/Modbus byte update for the command
// frame builder. No dependencies.
package cfb_pkg;

  localparam int MAX_PAYLOAD = 128;
  localparam logic [7:0] MAX_PAYLOAD_B = 8'(MAX_PAYLOAD);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] HDR0_BYTE = 8'h5A;
  localparam logic [7:0] HDR1_BYTE = 8'hA5;
  localparam logic [7:0] CMD0_BYTE = 8'h10;
  localparam logic [7:0] CMD1_BYTE = 8'h00;
  localparam logic [7:0] CMD2_BYTE = 8'h04;
  localparam logic [7:0] PAD_BYTE = 8'h00;
  localparam logic [8:0] LEN_OVERHEAD = 9'd5;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic [7:0] message_byte;
    logic [7:0] message_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } out_item_t;

  // One classified input item as it waits for the back end.
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] len_byte;
    logic       first;
    logic       empty;
    logic       last;
    logic       odd;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

endpackage

### rtl/cfb_front.sv
// Front end: accepts message bytes and classifies each as first, last, empty.
// Depends on cfb_pkg.
module cfb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cfb_pkg::in_item_t in_data,
  input  cfb_pkg::q_stat_t  q_stat,
  output logic              push,
  output cfb_pkg::entry_t   push_entry
);

  logic [7:0] remaining_r, remaining_nxt;
  logic       odd_r, odd_nxt;
  logic [7:0] n_sat;
  logic [7:0] count;
  logic [8:0] padded_len;
  logic       is_first;

  assign in_ready = !q_stat.full;
  assign push = in_valid && in_ready;

  always_comb begin
    is_first = (remaining_r == 8'd0);
    n_sat = (in_data.message_length > cfb_pkg::MAX_PAYLOAD_B) ? cfb_pkg::MAX_PAYLOAD_B
                                                               : in_data.message_length;
    count = is_first ? n_sat : remaining_r;
    padded_len = {1'b0, n_sat} + {8'd0, n_sat[0]} + cfb_pkg::LEN_OVERHEAD;

    push_entry.data = in_data.message_byte;
    push_entry.len_byte = padded_len[7:0];
    push_entry.first = is_first;
    push_entry.empty = is_first && (n_sat == 8'd0);
    push_entry.last = (count == 8'd1);
    push_entry.odd = is_first ? n_sat[0] : odd_r;

    remaining_nxt = remaining_r;
    odd_nxt = odd_r;
    if (push) begin
      remaining_nxt = push_entry.empty ? 8'd0 : count - 8'd1;
      odd_nxt = push_entry.odd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remaining_r <= 8'd0;
      odd_r <= 1'b0;
    end else begin
      remaining_r <= remaining_nxt;
      odd_r <= odd_nxt;
    end
  end

endmodule

### rtl/cfb_queue.sv
// Short register queue between front and back end.
// Depends on cfb_pkg.
module cfb_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cfb_pkg::entry_t  push_entry,
  input  logic             pop,
  output cfb_pkg::entry_t  head,
  output cfb_pkg::q_stat_t q_stat
);

  cfb_pkg::entry_t mem_r [cfb_pkg::QUEUE_DEPTH];
  logic [cfb_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [cfb_pkg::QPTR_W:0]   cnt_r, cnt_nxt;

  assign head = mem_r[rd_ptr_r];
  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full = (cnt_r == (cfb_pkg::QPTR_W+1)'(cfb_pkg::QUEUE_DEPTH));

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

endmodule

### rtl/cfb_back.sv
// Back end: sequences header, payload, pad and CRC bytes into the output register.
// Depends on cfb_pkg.
module cfb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  cfb_pkg::entry_t    head,
  input  cfb_pkg::q_stat_t   q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output cfb_pkg::out_item_t out_data
);

  typedef enum logic [3:0] {
    S_FETCH, S_H1, S_LEN, S_C0, S_C1, S_C2, S_DATA, S_PAD, S_CRCL, S_CRCH
  } state_t;

  state_t             state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  cfb_pkg::out_item_t out_data_r, out_data_nxt;
  logic [15:0]        crc_r, crc_nxt;
  logic               advance;
  logic               emit;

  assign advance = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  always_comb begin
    state_nxt = state_r;
    crc_nxt = crc_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pop = 1'b0;
    emit = advance && !q_stat.empty;

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt.frame_last = 1'b0;
      unique case (state_r)
        S_FETCH: begin
          if (head.first) begin
            out_data_nxt.frame_byte = cfb_pkg::HDR0_BYTE;
            state_nxt = S_H1;
          end else begin
            out_data_nxt.frame_byte = head.data;
            crc_nxt = cfb_pkg::crc_feed(crc_r, head.data);
            if (head.last) state_nxt = head.odd ? S_PAD : S_CRCL;
            else pop = 1'b1;
          end
        end
        S_H1: begin
          out_data_nxt.frame_byte = cfb_pkg::HDR1_BYTE;
          state_nxt = S_LEN;
        end
        S_LEN: begin
          out_data_nxt.frame_byte = head.len_byte;
          state_nxt = S_C0;
        end
        S_C0: begin
          out_data_nxt.frame_byte = cfb_pkg::CMD0_BYTE;
          crc_nxt = cfb_pkg::crc_feed(cfb_pkg::CRC_INIT, cfb_pkg::CMD0_BYTE);
          state_nxt = S_C1;
        end
        S_C1: begin
          out_data_nxt.frame_byte = cfb_pkg::CMD1_BYTE;
          crc_nxt = cfb_pkg::crc_feed(crc_r, cfb_pkg::CMD1_BYTE);
          state_nxt = S_C2;
        end
        S_C2: begin
          out_data_nxt.frame_byte = cfb_pkg::CMD2_BYTE;
          crc_nxt = cfb_pkg::crc_feed(crc_r, cfb_pkg::CMD2_BYTE);
          state_nxt = head.empty ? S_CRCL : S_DATA;
        end
        S_DATA: begin
          out_data_nxt.frame_byte = head.data;
          crc_nxt = cfb_pkg::crc_feed(crc_r, head.data);
          if (head.last) begin
            state_nxt = head.odd ? S_PAD : S_CRCL;
          end else begin
            pop = 1'b1;
            state_nxt = S_FETCH;
          end
        end
        S_PAD: begin
          out_data_nxt.frame_byte = cfb_pkg::PAD_BYTE;
          crc_nxt = cfb_pkg::crc_feed(crc_r, cfb_pkg::PAD_BYTE);
          state_nxt = S_CRCL;
        end
        S_CRCL: begin
          out_data_nxt.frame_byte = crc_r[7:0];
          state_nxt = S_CRCH;
        end
        S_CRCH: begin
          out_data_nxt.frame_byte = crc_r[15:8];
          out_data_nxt.frame_last = 1'b1;
          crc_nxt = cfb_pkg::CRC_INIT;
          pop = 1'b1;
          state_nxt = S_FETCH;
        end
        default: state_nxt = S_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FETCH;
      out_valid_r <= 1'b0;
      crc_r <= cfb_pkg::CRC_INIT;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      crc_r <= crc_nxt;
    end
    out_data_r <= out_data_nxt;
  end

endmodule

### rtl/command_frame_builder_crc16_top.sv
// Top level of the command frame builder: front end, queue and back end.
// Depends on cfb_pkg, cfb_front, cfb_queue and cfb_back.
//
// Wraps a message into a display command frame: 5A A5, length (padded
// payload + 5), 10 00 04, payload, a 00 pad if the length is odd, then
// CRC-16/Modbus over everything from the 10 byte on, low byte first; the CRC
// high byte carries frame_last. message_length is read on the first beat of
// a message only and saturates at MAX_PAYLOAD; a zero length gives the empty
// frame on one input beat. Each input beat is classified and queued by the
// front end, so input keeps flowing while the back end emits header and CRC
// bytes. The output side runs at one frame byte per cycle while out_ready is
// high and the queue is not empty, set by the single output register of the
// back-end sequencer: a message of n bytes gives n + 8 frame bytes (n + 9
// for odd n), so payload beats sustain one per cycle and the header and
// trailer bytes hold the input off once the four-entry queue fills.
module command_frame_builder_crc16_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cfb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cfb_pkg::out_item_t out_data
);

  // Queue status, head entry and the push/pop handshake between the parts.
  cfb_pkg::q_stat_t q_stat;
  cfb_pkg::entry_t  push_entry;
  cfb_pkg::entry_t  head;
  logic             push;
  logic             pop;

  // Classify each input beat; hold in_ready low while the queue is full.
  cfb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decouple the two sides.
  cfb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // Expand each entry into frame bytes and advance the CRC per covered byte.
  cfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/cfb_checker.sv
// Port-level checks on frame structure for the command frame builder.
// Depends on cfb_pkg; bound to command_frame_builder_crc16_top.
module cfb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input cfb_pkg::out_item_t out_data
);

  logic [7:0] pos_r;
  logic       out_fire;

  assign out_fire = out_valid && out_ready;

  // Count output beats within the current frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 8'd0;
    end else if (out_fire) begin
      if (out_data.frame_last) pos_r <= 8'd0;
      else if (pos_r != 8'hFF) pos_r <= pos_r + 8'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_hdr0: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && pos_r == 8'd0 |-> out_data.frame_byte == cfb_pkg::HDR0_BYTE)
    else $error("frame does not open with first header byte");

  a_hdr1: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && pos_r == 8'd1 |-> out_data.frame_byte == cfb_pkg::HDR1_BYTE)
    else $error("second header byte wrong");

  a_cmd0: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && pos_r == 8'd3 |-> out_data.frame_byte == cfb_pkg::CMD0_BYTE)
    else $error("command byte wrong");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_data.frame_last |-> pos_r >= 8'd7)
    else $error("frame ended too early");

endmodule

bind command_frame_builder_crc16_top cfb_checker u_cfb_checker (.*);
